// ===== hw/rtl/lseg_pkg.sv =====
`timescale 1ns / 1ps

package lseg_pkg;

	// effect codes
	localparam logic [1:0] FUNC_WIPE     = 2'd0;
	localparam logic [1:0] FUNC_CHASE    = 2'd1;
	localparam logic [1:0] FUNC_RAINBOW  = 2'd2;
	localparam logic [1:0] FUNC_RB_CHASE = 2'd3;

	// wheel segment bounds and counter limits
	localparam logic [7:0] SEG_ONE      = 8'd85;
	localparam logic [7:0] SEG_TWO      = 8'd170;
	localparam logic [7:0] LEVEL_MAX    = 8'd255;
	localparam logic [8:0] HUE_MOD      = 9'd255;
	localparam logic [1:0] PHASE_LAST   = 2'd2;
	localparam logic [3:0] ROUNDS_LAST  = 4'd9;

	typedef struct packed {
		logic [1:0]  func;
		logic [23:0] color;
	} in_t;

	typedef struct packed {
		logic [4:0] pixel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} out_t;

	// hue wheel: three linear segments over 0..255
	function automatic logic [23:0] wheel(input logic [7:0] pos);
		logic [7:0] q;
		logic [7:0] seg;
		logic [7:0] up;
		logic [7:0] dn;
		logic [23:0] rgb;
		q = ~pos;
		if (q < SEG_ONE) begin
			seg = q;
		end else if (q < SEG_TWO) begin
			seg = q - SEG_ONE;
		end else begin
			seg = q - SEG_TWO;
		end
		up = (seg << 1) + seg;
		dn = LEVEL_MAX - up;
		if (q < SEG_ONE) begin
			rgb = {dn, 8'd0, up};
		end else if (q < SEG_TWO) begin
			rgb = {8'd0, up, dn};
		end else begin
			rgb = {up, dn, 8'd0};
		end
		return rgb;
	endfunction

endpackage

// ===== hw/rtl/lseg_ram.sv =====
`timescale 1ns / 1ps

module lseg_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port that holds when idle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/led_strip_effect_generator_unit.sv =====
`timescale 1ns / 1ps

// LED strip effect generator. Each request is one animation step (wipe, chase,
// rainbow or rainbow chase) and answers with the whole frame, PIXELS results
// in pixel order with last_pixel set on the final one. The frame sits in a
// single-port-read memory; every step sweeps it once, reading, recolouring,
// emitting and writing back one pixel per cycle while the output is not
// stalled, and the next request is taken only after the final pixel has left
// the memory stage. The frame reads as black after reset through per-pixel
// valid bits; there is no clearing pass.
module led_strip_effect_generator_unit
	import lseg_pkg::*;
#(
	parameter int PIXELS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);

	localparam int IW = $clog2(PIXELS);
	localparam int CW = $clog2(PIXELS + 1);
	localparam logic [CW-1:0] PIX_END  = CW'(PIXELS);
	localparam logic [IW-1:0] PIX_LAST = IW'(PIXELS - 1);

	logic              busy_q;
	logic [1:0]        func_q;
	logic [23:0]       color_q;
	logic [IW-1:0]     wpos_q;
	logic [1:0]        cphase_q;
	logic [3:0]        crounds_q;
	logic [7:0]        hue_q;
	logic [1:0]        rphase_q;
	logic [CW-1:0]     ptr_q;
	logic [1:0]        ptr_mod_q;
	logic [PIXELS-1:0] vld_q;

	logic              valid_s1;
	logic [IW-1:0]     idx_s1;
	logic [1:0]        mod_s1;

	logic              out_valid_q;
	out_t              out_data_q;

	logic              accept;
	logic              adv;
	logic              rd_go;
	logic              wr_go;
	logic              done;
	logic [23:0]       rdata;
	logic [23:0]       old_px;
	logic [23:0]       emit_px;
	logic [23:0]       keep_px;
	logic [8:0]        hsum;
	logic [8:0]        hrc;
	logic [8:0]        hrc_mod;
	logic [IW+4:0]     idx_ext;

	assign accept    = in_valid && !busy_q;
	assign in_stall  = busy_q;
	assign adv       = !out_valid_q || !out_stall;
	assign rd_go     = busy_q && (ptr_q != PIX_END) && (!valid_s1 || adv);
	assign wr_go     = valid_s1 && adv;
	assign done      = wr_go && (idx_s1 == PIX_LAST);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	lseg_ram #(
		.WIDTH(24),
		.DEPTH(PIXELS)
	) u_frame (
		.clk  (clk),
		.we   (wr_go),
		.waddr(idx_s1),
		.wdata(keep_px),
		.re   (rd_go),
		.raddr(ptr_q[IW-1:0]),
		.rdata(rdata)
	);

	// per-pixel recolouring of the word just read
	always_comb begin
		old_px  = vld_q[idx_s1] ? rdata : 24'd0;
		hsum    = 9'(idx_s1) + 9'(hue_q);
		hrc     = hsum - 9'(rphase_q);
		hrc_mod = (hrc >= HUE_MOD) ? (hrc - HUE_MOD) : hrc;
		emit_px = old_px;
		keep_px = old_px;
		case (func_q)
			FUNC_WIPE: begin
				if (idx_s1 == wpos_q) begin
					emit_px = color_q;
				end
				keep_px = emit_px;
			end
			FUNC_CHASE: begin
				emit_px = (mod_s1 == cphase_q) ? color_q : 24'd0;
				keep_px = emit_px;
			end
			FUNC_RAINBOW: begin
				emit_px = wheel(hsum[7:0]);
				keep_px = emit_px;
			end
			FUNC_RB_CHASE: begin
				if (mod_s1 == rphase_q) begin
					emit_px = wheel(hrc_mod[7:0]);
					keep_px = 24'd0;
				end
			end
			default: begin
				emit_px = old_px;
				keep_px = old_px;
			end
		endcase
		idx_ext = {5'd0, idx_s1};
	end

	// request intake and sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			ptr_q     <= '0;
			ptr_mod_q <= 2'd0;
			valid_s1  <= 1'b0;
		end else begin
			if (accept) begin
				busy_q    <= 1'b1;
				ptr_q     <= '0;
				ptr_mod_q <= 2'd0;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (rd_go) begin
				ptr_q     <= ptr_q + CW'(1);
				ptr_mod_q <= (ptr_mod_q == PHASE_LAST) ? 2'd0 : ptr_mod_q + 2'd1;
				valid_s1  <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// latched request and read-stage tags
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= in_data.func;
			color_q <= in_data.color;
		end
		if (rd_go) begin
			idx_s1 <= ptr_q[IW-1:0];
			mod_s1 <= ptr_mod_q;
		end
	end

	// pixel valid bits, frame reads black until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_go) begin
			vld_q[idx_s1] <= 1'b1;
		end
	end

	// effect counters, advanced once the final pixel is out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q    <= '0;
			cphase_q  <= 2'd0;
			crounds_q <= 4'd0;
			hue_q     <= 8'd0;
			rphase_q  <= 2'd0;
		end else if (done) begin
			case (func_q)
				FUNC_WIPE: begin
					wpos_q <= (wpos_q == PIX_LAST) ? '0 : wpos_q + IW'(1);
				end
				FUNC_CHASE: begin
					if (cphase_q == PHASE_LAST) begin
						cphase_q  <= 2'd0;
						crounds_q <= (crounds_q == ROUNDS_LAST) ? 4'd0 : crounds_q + 4'd1;
					end else begin
						cphase_q <= cphase_q + 2'd1;
					end
				end
				FUNC_RAINBOW: begin
					hue_q <= hue_q + 8'd1;
				end
				FUNC_RB_CHASE: begin
					rphase_q <= (rphase_q == PHASE_LAST) ? 2'd0 : rphase_q + 2'd1;
					hue_q    <= hue_q + 8'd1;
				end
				default: begin
					hue_q <= hue_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_go) begin
			out_data_q.pixel_index <= idx_ext[4:0];
			out_data_q.red         <= emit_px[23:16];
			out_data_q.green       <= emit_px[15:8];
			out_data_q.blue        <= emit_px[7:0];
			out_data_q.last_pixel  <= (idx_s1 == PIX_LAST);
		end
	end

	// checks
	a_s1_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> busy_q)
		else $error("read stage holds a pixel outside a sweep");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy_q && !valid_s1)
		else $error("sweep did not close after the final pixel");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && (ptr_q == '0) && !valid_s1)
		else $error("sweep did not start from pixel zero");

endmodule
